/* sv/gss_pkg.sv */
// ============================================================================
// gss_pkg: shared types and constants of the golden-section search sequencer
// Holds fixed-point constants, reset values, codes and the structs that
// travel between the front queue, the back sequencer and the result queue.
// ============================================================================
package gss_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [31:0] INV_PHI_Q32 = 32'd2654435769;
  localparam logic [63:0] HALF_Q32    = 64'h0000_0000_8000_0000;

  localparam logic signed [31:0] LEFT_RESET  = -(32'sd5 <<< FRAC_BITS);
  localparam logic signed [31:0] RIGHT_RESET = 32'sd5 <<< FRAC_BITS;
  localparam logic [30:0]        TOL_RESET   =
    31'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  localparam logic [1:0] REG_LEFT_START  = 2'd0;
  localparam logic [1:0] REG_RIGHT_START = 2'd1;
  localparam logic [1:0] REG_TOLERANCE   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LOWER = 2'd1,
    PH_UPPER = 2'd2,
    PH_RUN   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SQ_DECIDE = 2'd0,
    SQ_MUL    = 2'd1,
    SQ_FINISH = 2'd2
  } seq_t;

  typedef enum logic [1:0] {
    UPD_START = 2'd0,
    UPD_LOWER = 2'd1,
    UPD_UPPER = 2'd2
  } upd_t;

  typedef enum logic [1:0] {
    KIND_REQUEST  = 2'd0,
    KIND_PROGRESS = 2'd1,
    KIND_FINAL    = 2'd2
  } res_kind_t;

  typedef enum logic {
    ITEM_START = 1'b0,
    ITEM_VALUE = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic signed [31:0] left_start;
    logic signed [31:0] right_start;
    logic [30:0]        tolerance;
  } cfg_t;

  typedef struct packed {
    item_kind_t         kind;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_src_t;

  typedef struct packed {
    res_kind_t          kind;
    logic signed [31:0] point;
    logic               last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  typedef struct packed {
    logic room;
    logic full;
  } qstat_t;

endpackage

/* sv/gss_front.sv */
// ============================================================================
// gss_front: request intake queue
// Accepts requests from the input channel, tags each one as a search start
// or a returned objective value, and holds up to two for the sequencer.
// ============================================================================
module gss_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // objective_value
  input  logic               in_tuser,   // opcode
  output gss_pkg::item_src_t src,
  input  logic               pop
);

  gss_pkg::item_t mem_r [2];
  logic           wr_r, wr_nxt;
  logic           rd_r, rd_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           accept;
  gss_pkg::item_t item_in;

  always_comb begin
    in_tready     = (cnt_r != 2'd2);
    accept        = in_tvalid && in_tready;
    item_in.kind  = in_tuser ? gss_pkg::ITEM_VALUE : gss_pkg::ITEM_START;
    item_in.value = in_tdata;
    src.valid     = (cnt_r != 2'd0);
    src.item      = mem_r[rd_r];
    wr_nxt        = accept ? ~wr_r : wr_r;
    rd_nxt        = pop ? ~rd_r : rd_r;
    case ({accept, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_r] <= item_in;
    end
  end

endmodule

/* sv/gss_back.sv */
// ============================================================================
// gss_back: golden-section search sequencer
// Holds the interval, probes and objective values, narrows the interval on
// each returned value and computes new probes with a 1/phi multiplier.
// ============================================================================
module gss_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gss_pkg::cfg_t      cfg,
  input  gss_pkg::item_src_t src,
  output logic               pop,
  input  gss_pkg::qstat_t    stat,
  output gss_pkg::push_t     push
);

  gss_pkg::phase_t    phase_r, phase_nxt;
  gss_pkg::seq_t      seq_r, seq_nxt;
  gss_pkg::upd_t      upd_r, upd_nxt;
  logic               pend_r, pend_nxt;
  logic signed [31:0] left_r, left_nxt;
  logic signed [31:0] right_r, right_nxt;
  logic signed [31:0] lprobe_r, lprobe_nxt;
  logic signed [31:0] uprobe_r, uprobe_nxt;
  logic signed [31:0] lval_r, lval_nxt;
  logic signed [31:0] uval_r, uval_nxt;
  logic [31:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        prod_r, prod_nxt;

  function automatic logic [31:0] abs_mag(input logic signed [32:0] w);
    logic [32:0] m;
    m = w[32] ? -w : w;
    return m[31:0];
  endfunction

  always_comb begin
    logic signed [32:0] w_start;
    logic signed [32:0] w_now;
    logic signed [32:0] w_new;
    logic signed [32:0] off;
    logic [32:0]        sum;
    logic [32:0]        lo_full;
    logic [32:0]        up_full;
    logic [63:0]        prod_full;
    logic signed [31:0] mid;
    logic signed [31:0] lv;
    logic signed [31:0] uv;

    phase_nxt  = phase_r;
    seq_nxt    = seq_r;
    upd_nxt    = upd_r;
    pend_nxt   = pend_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    lprobe_nxt = lprobe_r;
    uprobe_nxt = uprobe_r;
    lval_nxt   = lval_r;
    uval_nxt   = uval_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    prod_nxt   = prod_r;
    pop        = 1'b0;
    push       = '0;

    w_start = {cfg.right_start[31], cfg.right_start} - {cfg.left_start[31], cfg.left_start};
    w_now   = {right_r[31], right_r} - {left_r[31], left_r};
    sum     = {left_r[31], left_r} + {right_r[31], right_r};
    mid     = sum[32:1];
    w_new   = '0;
    lv      = (phase_r == gss_pkg::PH_RUN && pend_r) ? src.item.value : lval_r;
    uv      = (phase_r == gss_pkg::PH_UPPER || (phase_r == gss_pkg::PH_RUN && !pend_r))
              ? src.item.value : uval_r;

    prod_full = mag_r * gss_pkg::INV_PHI_Q32;
    prod_full = prod_full + gss_pkg::HALF_Q32;
    off       = neg_r ? -$signed({1'b0, prod_r}) : $signed({1'b0, prod_r});
    lo_full   = {right_r[31], right_r} - off;
    up_full   = {left_r[31], left_r} + off;

    case (seq_r)
      gss_pkg::SQ_DECIDE: begin
        if (src.valid && stat.room) begin
          pop = 1'b1;
          if (src.item.kind == gss_pkg::ITEM_START) begin
            left_nxt  = cfg.left_start;
            right_nxt = cfg.right_start;
            mag_nxt   = abs_mag(w_start);
            neg_nxt   = w_start[32];
            upd_nxt   = gss_pkg::UPD_START;
            pend_nxt  = 1'b1;
            phase_nxt = gss_pkg::PH_LOWER;
            seq_nxt   = gss_pkg::SQ_MUL;
          end else begin
            case (phase_r)
              gss_pkg::PH_LOWER: begin
                lval_nxt       = src.item.value;
                pend_nxt       = 1'b0;
                phase_nxt      = gss_pkg::PH_UPPER;
                push.valid     = 1'b1;
                push.res.kind  = gss_pkg::KIND_REQUEST;
                push.res.point = uprobe_r;
                push.res.last  = 1'b1;
              end
              gss_pkg::PH_UPPER, gss_pkg::PH_RUN: begin
                push.valid     = 1'b1;
                push.res.point = mid;
                lval_nxt       = lv;
                uval_nxt       = uv;
                if (w_now > $signed({2'b00, cfg.tolerance})) begin
                  push.res.kind = gss_pkg::KIND_PROGRESS;
                  push.res.last = 1'b0;
                  if (lv < uv) begin
                    right_nxt  = uprobe_r;
                    uprobe_nxt = lprobe_r;
                    uval_nxt   = lv;
                    w_new      = {uprobe_r[31], uprobe_r} - {left_r[31], left_r};
                    upd_nxt    = gss_pkg::UPD_LOWER;
                    pend_nxt   = 1'b1;
                  end else begin
                    left_nxt   = lprobe_r;
                    lprobe_nxt = uprobe_r;
                    lval_nxt   = uv;
                    w_new      = {right_r[31], right_r} - {lprobe_r[31], lprobe_r};
                    upd_nxt    = gss_pkg::UPD_UPPER;
                    pend_nxt   = 1'b0;
                  end
                  mag_nxt   = abs_mag(w_new);
                  neg_nxt   = w_new[32];
                  phase_nxt = gss_pkg::PH_RUN;
                  seq_nxt   = gss_pkg::SQ_MUL;
                end else begin
                  push.res.kind = gss_pkg::KIND_FINAL;
                  push.res.last = 1'b1;
                  phase_nxt     = gss_pkg::PH_IDLE;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      gss_pkg::SQ_MUL: begin
        prod_nxt = prod_full[63:32];
        seq_nxt  = gss_pkg::SQ_FINISH;
      end
      gss_pkg::SQ_FINISH: begin
        push.valid    = 1'b1;
        push.res.kind = gss_pkg::KIND_REQUEST;
        push.res.last = 1'b1;
        case (upd_r)
          gss_pkg::UPD_START: begin
            lprobe_nxt     = lo_full[31:0];
            uprobe_nxt     = up_full[31:0];
            push.res.point = lo_full[31:0];
          end
          gss_pkg::UPD_LOWER: begin
            lprobe_nxt     = lo_full[31:0];
            push.res.point = lo_full[31:0];
          end
          default: begin
            uprobe_nxt     = up_full[31:0];
            push.res.point = up_full[31:0];
          end
        endcase
        seq_nxt = gss_pkg::SQ_DECIDE;
      end
      default: begin
        seq_nxt = gss_pkg::SQ_DECIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gss_pkg::PH_IDLE;
      seq_r   <= gss_pkg::SQ_DECIDE;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    upd_r    <= upd_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    lprobe_r <= lprobe_nxt;
    uprobe_r <= uprobe_nxt;
    lval_r   <= lval_nxt;
    uval_r   <= uval_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    prod_r   <= prod_nxt;
  end

endmodule

/* sv/gss_out_queue.sv */
// ============================================================================
// gss_out_queue: result queue
// Four-entry queue that decouples the sequencer from the output channel and
// reports whether room for the two results of one request is left.
// ============================================================================
module gss_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  gss_pkg::push_t  push,
  output gss_pkg::qstat_t stat,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,  // point
  output logic [1:0]      out_tuser,  // kind
  output logic            out_tlast   // last
);

  gss_pkg::res_t mem_r [4];
  logic [1:0]    wr_r, wr_nxt;
  logic [1:0]    rd_r, rd_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          take;

  always_comb begin
    out_tvalid = (cnt_r != 3'd0);
    take       = out_tvalid && out_tready;
    out_tdata  = mem_r[rd_r].point;
    out_tuser  = mem_r[rd_r].kind;
    out_tlast  = mem_r[rd_r].last;
    stat.room  = (cnt_r <= 3'd2);
    stat.full  = (cnt_r == 3'd4);
    wr_nxt     = push.valid ? wr_r + 2'd1 : wr_r;
    rd_nxt     = take ? rd_r + 2'd1 : rd_r;
    case ({push.valid, take})
      2'b10:   cnt_nxt = cnt_r + 3'd1;
      2'b01:   cnt_nxt = cnt_r - 3'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_r] <= push.res;
    end
  end

endmodule

/* sv/golden_section_line_search_top.sv */
// ============================================================================
// golden_section_line_search_top: golden-section search of a 1-D minimum
// Emits points at which the objective is to be evaluated, takes the values
// back and narrows the interval until its width is within the tolerance.
// ============================================================================
// A start request loads the interval from the configuration registers and
// asks for the objective at the two inner probes, one after the other. Each
// later value request narrows the interval, reports the midpoint and asks for
// one new probe, until the final midpoint is sent with tlast set. The
// sequencer handles the value for the first probe, the value that ends a
// search and a value that arrives while no search runs in its decide step
// alone, and takes a start and any other value through decide, multiply and
// probe update, since every new probe needs the registered 32 x 32 bit
// multiply by 1/phi. A request is only decided while the result queue has
// room for two results. A two-entry intake queue takes requests while the
// sequencer works, and a four-entry result queue holds results while the
// output channel stalls.
module golden_section_line_search_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // objective_value
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // point
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  gss_pkg::cfg_t      cfg_r, cfg_nxt;
  gss_pkg::item_src_t src;
  logic               pop;
  gss_pkg::push_t     push;
  gss_pkg::qstat_t    stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gss_pkg::REG_LEFT_START:  cfg_nxt.left_start  = cfg_wdata;
        gss_pkg::REG_RIGHT_START: cfg_nxt.right_start = cfg_wdata;
        gss_pkg::REG_TOLERANCE:   cfg_nxt.tolerance   = cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_start  <= gss_pkg::LEFT_RESET;
      cfg_r.right_start <= gss_pkg::RIGHT_RESET;
      cfg_r.tolerance   <= gss_pkg::TOL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .src       (src),
    .pop       (pop)
  );

  gss_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .src   (src),
    .pop   (pop),
    .stat  (stat),
    .push  (push)
  );

  gss_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !stat.full)
    else $error("Result written into a full queue.");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> src.valid)
    else $error("Sequencer took a request from an empty intake queue.");

  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == gss_pkg::KIND_FINAL) |-> out_tlast)
    else $error("Final estimate sent without tlast.");

  a_progress_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == gss_pkg::KIND_PROGRESS) |-> !out_tlast)
    else $error("Progress midpoint sent with tlast.");

endmodule

/* test/gss_probe_check.sv */
`timescale 1ns / 1ps
// ============================================================================
// gss_probe_check: result prediction and comparison for the search sequencer
// Watches the configuration port and both stream channels, keeps its own
// model of the search interval and probes, and compares each result that
// leaves the block with the oldest predicted one.
// ============================================================================
module gss_probe_check
  import gss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // objective_value
  input  logic        in_tuser,   // opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // point
  input  logic [1:0]  out_tuser,  // kind
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          due_count,
  output logic        search_busy
);

  localparam logic [63:0] RECIP_PHI  = 64'd2654435769;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;
  localparam int          REPORT_CAP = 100;

  logic signed [31:0] left_cfg;
  logic signed [31:0] right_cfg;
  logic [30:0]        tol_cfg;

  phase_t             search_phase;
  logic signed [31:0] left_end;
  logic signed [31:0] right_end;
  logic signed [31:0] lower_probe;
  logic signed [31:0] upper_probe;
  logic signed [31:0] lower_value;
  logic signed [31:0] upper_value;
  logic               awaiting_lower;

  res_t due_results[$];
  res_t oldest;
  int   errors;

  function automatic logic signed [63:0] probe_offset(input logic signed [63:0] width);
    logic [63:0] mag;
    logic [63:0] scaled;
    mag = width[63] ? 64'(-width) : 64'(width);
    scaled = (mag * RECIP_PHI + ROUND_HALF) >> 32;
    return width[63] ? -$signed(scaled) : $signed(scaled);
  endfunction

  function automatic logic signed [31:0] interval_mid(input logic signed [31:0] lo,
                                                      input logic signed [31:0] hi);
    logic signed [32:0] total;
    total = lo + hi;
    return total[32:1];
  endfunction

  task automatic post_result(input res_kind_t kind, input logic signed [31:0] point,
                             input logic last);
    res_t r;
    r.kind = kind;
    r.point = point;
    r.last = last;
    due_results = {due_results, r};
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_CAP)
        $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
    end
  endtask

  // Once both probe values are known, either report the final midpoint or
  // drop the worse side and ask for the one probe that is missing.
  task automatic narrow_interval();
    logic signed [63:0] width;
    width = right_end - left_end;
    if (width > $signed({33'd0, tol_cfg})) begin
      post_result(KIND_PROGRESS, interval_mid(left_end, right_end), 1'b0);
      if (lower_value < upper_value) begin
        right_end = upper_probe;
        upper_probe = lower_probe;
        upper_value = lower_value;
        width = right_end - left_end;
        lower_probe = 32'(right_end - probe_offset(width));
        awaiting_lower = 1'b1;
        post_result(KIND_REQUEST, lower_probe, 1'b1);
      end else begin
        left_end = lower_probe;
        lower_probe = upper_probe;
        lower_value = upper_value;
        width = right_end - left_end;
        upper_probe = 32'(left_end + probe_offset(width));
        awaiting_lower = 1'b0;
        post_result(KIND_REQUEST, upper_probe, 1'b1);
      end
      search_phase = PH_RUN;
    end else begin
      post_result(KIND_FINAL, interval_mid(left_end, right_end), 1'b1);
      search_phase = PH_IDLE;
    end
  endtask

  task automatic take_request(input logic op, input logic signed [31:0] value);
    logic signed [63:0] width;
    logic signed [63:0] offset;
    if (op == ITEM_START) begin
      left_end = left_cfg;
      right_end = right_cfg;
      width = right_end - left_end;
      offset = probe_offset(width);
      lower_probe = 32'(right_end - offset);
      upper_probe = 32'(left_end + offset);
      awaiting_lower = 1'b1;
      search_phase = PH_LOWER;
      post_result(KIND_REQUEST, lower_probe, 1'b1);
    end else begin
      case (search_phase)
        PH_LOWER: begin
          lower_value = value;
          awaiting_lower = 1'b0;
          search_phase = PH_UPPER;
          post_result(KIND_REQUEST, upper_probe, 1'b1);
        end
        PH_UPPER: begin
          upper_value = value;
          narrow_interval();
        end
        PH_RUN: begin
          if (awaiting_lower)
            lower_value = value;
          else
            upper_value = value;
          narrow_interval();
        end
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      left_cfg = -32'sd327680;
      right_cfg = 32'sd327680;
      tol_cfg = 31'd7;
      search_phase = PH_IDLE;
      left_end = '0;
      right_end = '0;
      lower_probe = '0;
      upper_probe = '0;
      lower_value = '0;
      upper_value = '0;
      awaiting_lower = 1'b0;
      due_results.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $error("unexpected result: kind %0d, point %0d, last %0d",
                   out_tuser, $signed(out_tdata), out_tlast);
        end else begin
          oldest = due_results.pop_front();
          check_field("kind", 32'(oldest.kind), 32'(out_tuser));
          check_field("point", oldest.point, out_tdata);
          check_field("last", 32'(oldest.last), 32'(out_tlast));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_START:  left_cfg = cfg_wdata;
          REG_RIGHT_START: right_cfg = cfg_wdata;
          REG_TOLERANCE:   tol_cfg = cfg_wdata[30:0];
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready)
        take_request(in_tuser, in_tdata);
    end
    fail_count <= errors;
    due_count <= due_results.size();
    search_busy <= (search_phase != PH_IDLE);
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: stimulus and verdict for the golden-section search sequencer
// Drives directed and random searches through the block under changing
// interval and tolerance settings and random stalls on both channels, while
// gss_probe_check predicts and compares every result.
// ============================================================================
module tb_top;
  import gss_pkg::*;

  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 185;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // objective_value
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // point
  logic [1:0]  out_tuser;  // kind
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int          fail_count;
  int          due_count;
  logic        search_busy;

  int          feed_idle;
  int          drain_stall;
  int          quiet_cycles;
  int          items_sent;
  logic [31:0] last_value;

  golden_section_line_search_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  gss_probe_check probe_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .due_count   (due_count),
    .search_busy (search_busy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= drain_stall);
  end

  function automatic logic [31:0] objective_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return last_value;
      3, 4:    return $urandom_range(0, 2000) - 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(input logic op, input logic [31:0] value);
    while ($urandom_range(0, 99) < feed_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= value;
    last_value = value;
    items_sent++;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  // The busy flag lags one request behind, so a search that runs to its end
  // is followed by one value that the block ignores.
  task automatic run_search(input int max_values);
    int n;
    n = 0;
    send_request(ITEM_START, $urandom());
    do begin
      send_request(ITEM_VALUE, objective_sample());
      n++;
    end while (search_busy && n < max_values);
  endtask

  // Finishes any open search, then waits until every result is out and the
  // block has had time to drop requests that cause none.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (search_busy)
      send_request(ITEM_VALUE, objective_sample());
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] left, input logic [31:0] right,
                            input logic [30:0] tol);
    cfg_we <= 1'b1;
    cfg_index <= REG_LEFT_START;
    cfg_wdata <= left;
    @(posedge clk);
    cfg_index <= REG_RIGHT_START;
    cfg_wdata <= right;
    @(posedge clk);
    cfg_index <= REG_TOLERANCE;
    cfg_wdata <= {1'b0, tol};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [31:0] left;
    logic [31:0] right;
    logic [30:0] tol;
    left = $urandom();
    case ($urandom_range(0, 3))
      0: begin
        left = $urandom_range(0, 2000000) - 32'd1000000;
        right = left + $urandom_range(1, 1000000);
      end
      1:       right = left + $urandom();
      2:       right = left - $urandom_range(0, 64);
      default: right = left + $urandom_range(1, 200);
    endcase
    case ($urandom_range(0, 2))
      0:       tol = 31'd1;
      1:       tol = 31'($urandom_range(1, 64));
      default: tol = 31'($urandom_range(1, 32'h7fff_ffff));
    endcase
    set_config(left, right, tol);
  endtask

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int first_item;
    int pick;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    feed_idle = 0;
    drain_stall = 0;
    items_sent = 0;
    last_value = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // A value while no search runs is dropped.
    send_request(ITEM_VALUE, 32'h7fff_ffff);
    settle();

    // A few steps each way and new starts in the middle of a search.
    set_config(32'd0, 32'd1000, 31'd100);
    send_request(ITEM_START, 32'h0);
    send_request(ITEM_VALUE, 32'h8000_0000);
    send_request(ITEM_VALUE, 32'h7fff_ffff);
    send_request(ITEM_VALUE, 32'h0);
    send_request(ITEM_VALUE, 32'h0);
    send_request(ITEM_START, 32'hffff_ffff);
    send_request(ITEM_VALUE, 32'd5);
    send_request(ITEM_START, 32'h0);
    settle();

    // Already narrow at start, reversed ends, and the widest interval.
    set_config(32'd100, 32'd105, 31'd7);
    run_search(8);
    settle();
    set_config(32'h7fff_ffff, 32'h8000_0000, 31'd1);
    run_search(8);
    settle();
    set_config(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    run_search(8);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          feed_idle <= 0;
          drain_stall <= 0;
        end
        1: begin
          feed_idle <= 77;
          drain_stall <= 0;
        end
        2: begin
          feed_idle <= 0;
          drain_stall <= 77;
        end
        default: begin
          feed_idle <= 29;
          drain_stall <= 29;
        end
      endcase
      if (ph == 0)
        set_config(-32'sd327680, 32'sd327680, 31'd7);
      else if (ph == 5)
        set_config(32'h8000_0000, 32'h7fff_ffff, 31'd1);
      else
        random_config();
      first_item = items_sent;
      while (items_sent - first_item < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 82)
          run_search(200);
        else if (pick < 94)
          run_search($urandom_range(1, 5));
        else
          send_request(ITEM_VALUE, objective_sample());
      end
      settle();
    end

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
